@@ hdl/pslg_pkg.sv @@
// package for the phased sine length generator: field widths, register
// indexes, sequencer states, wave parameter word and the quarter-sine builder
// no dependencies
package pslg_pkg;

  localparam int unsigned CHANNELS_DEF  = 8;
  localparam int unsigned SINE_BITS_DEF = 10;

  localparam longint unsigned TWOPI_Q30 = 64'd6746518853;
  localparam longint unsigned ONE_Q30   = 64'd1073741824;

  localparam int unsigned IN_TDATA_W  = 144;
  localparam int unsigned OUT_TDATA_W = 40;

  // register indexes, decoded from paddr bit 2
  localparam logic REG_LOWER = 1'b0;
  localparam logic REG_UPPER = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_ADV,
    ST_PH,
    ST_SIN,
    ST_MUL,
    ST_RND,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [31:0] offset;
    logic [23:0] phase_step;
    logic [23:0] frequency;
    logic [31:0] amplitude;
  } wave_t;

  // sine of r / 2^stb turns for 0 <= r <= quarter turn, Q1.30, elaboration only
  function automatic logic [30:0] quarter_sine(input longint unsigned r,
                                               input int unsigned stb);
    longint unsigned t;
    longint unsigned t2;
    longint unsigned term;
    longint unsigned prod;
    longint unsigned sub;
    t    = (r * TWOPI_Q30 + (64'd1 << (stb - 1))) >> stb;
    t2   = (t * t) >> 30;
    term = ONE_Q30;
    for (int k = 0; k < 6; k++) begin
      prod = (t2 * term) >> 30;
      case (k)
        0:       sub = prod / 64'd156;
        1:       sub = prod / 64'd110;
        2:       sub = prod / 64'd72;
        3:       sub = prod / 64'd42;
        4:       sub = prod / 64'd20;
        default: sub = prod / 64'd6;
      endcase
      term = (sub >= ONE_Q30) ? 64'd0 : ONE_Q30 - sub;
    end
    t = (t * term) >> 30;
    if (t > ONE_Q30) begin
      t = ONE_Q30;
    end
    return t[30:0];
  endfunction

endpackage

@@ hdl/pslg_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module pslg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hdl/phased_sine_length_generator_unit.sv @@
// Multi-channel sine target generator. Wave parameters of every channel sit
// in one ram and the phase accumulators in another; a tick walks the channels
// and streams one clamped target length word per channel.
// Input stream: tuser[0] = func. func 1 loads one channel's amplitude,
// frequency, phase step and offset in the accepting cycle and gives no word.
// func 0 is a tick: every channel's accumulator advances by frequency times
// time step and one word per channel comes out in channel order, tlast on
// the last one.
// Sequence: after the accepting cycle, a tick walks each channel through
// the steps ram read, advance multiply, phase and table address, sine table
// read, amplitude multiply, rounding and output before the next channel's
// ram read. The input is taken only while no tick is in progress; a word
// waiting on the output does not hold off the next input.
// A stalled receiver holds the output register; the walk pauses at the
// output step of the next channel until the word is taken.
// Reset empties the output, clears the per-entry valid bits so that all
// channel state reads as zero, and sets the limits to 0 and 0x7fffffff.
// Limits are written through the apb port at 0x0 (lower) and 0x4 (upper).
module phased_sine_length_generator_unit #(
  parameter int unsigned CHANNELS        = pslg_pkg::CHANNELS_DEF,
  parameter int unsigned SINE_TABLE_BITS = pslg_pkg::SINE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // time_step, channel_select, amplitude_in, frequency_in, phase_step_in,
  // offset_in from bit 0 up, zero pad to 144 bits
  input  logic [pslg_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // func
  input  logic [0:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // channel, target_length from bit 0 up, zero pad to 40 bits
  output logic [pslg_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                               m_axis_tlast,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int unsigned CW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned QUARTER = 1 << (SINE_TABLE_BITS - 2);
  localparam int unsigned RW      = SINE_TABLE_BITS - 1;
  localparam int unsigned WAVE_W  = $bits(pslg_pkg::wave_t);

  // quarter-wave sine table, built at elaboration
  logic [30:0] sine_rom [QUARTER+1];
  for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
    localparam logic [30:0] SINE_VAL = pslg_pkg::quarter_sine(64'(g), SINE_TABLE_BITS);
    assign sine_rom[g] = SINE_VAL;
  end

  // input fields
  logic [23:0] in_time_step;
  logic [2:0]  in_channel_select;
  logic [CW+2:0] sel_ext;
  logic        sel_in_range;
  pslg_pkg::wave_t in_wave;

  assign in_time_step         = s_axis_tdata[23:0];
  assign in_channel_select    = s_axis_tdata[26:24];
  assign in_wave.amplitude    = s_axis_tdata[58:27];
  assign in_wave.frequency    = s_axis_tdata[82:59];
  assign in_wave.phase_step   = s_axis_tdata[106:83];
  assign in_wave.offset       = s_axis_tdata[138:107];
  assign sel_ext              = (CW+3)'(in_channel_select);
  assign sel_in_range         = sel_ext < (CW+3)'(CHANNELS);

  pslg_pkg::state_e state_q, state_d;

  logic [CW-1:0]       ch_q;
  logic [CHANNELS-1:0] wave_valid_q;
  logic [CHANNELS-1:0] acc_valid_q;
  logic                m_valid_q;
  logic [2:0]          m_chan_q;
  logic [31:0]         m_len_q;
  logic                m_last_q;
  logic signed [31:0]  lower_q;
  logic signed [31:0]  upper_q;

  logic [23:0]        ts_q;
  logic [23:0]        lead_q;
  logic [23:0]        adv_q;
  logic [23:0]        acc_q;
  logic [31:0]        am_q;
  logic               amp_neg_q;
  logic               sin_neg_q;
  logic [31:0]        off_q;
  logic [23:0]        step_q;
  logic [RW-1:0]      rom_addr_q;
  logic [30:0]        sine_q;
  logic [62:0]        mul_q;
  logic [31:0]        mag_q;

  // control from the sequencer
  logic tick_start;
  logic wave_we;
  logic acc_we;
  logic out_load;
  logic ch_last;

  pslg_pkg::wave_t wave_rdata;
  pslg_pkg::wave_t wave_cur;
  logic [23:0]     acc_rdata;

  // each channel is read and written back before the next one is read,
  // so accesses to one entry never overlap
  pslg_ram #(
    .WIDTH (WAVE_W),
    .DEPTH (CHANNELS)
  ) u_wave_ram (
    .clk_i   (clk_i),
    .we_i    (wave_we),
    .waddr_i (sel_ext[CW-1:0]),
    .wdata_i (in_wave),
    .raddr_i (ch_q),
    .rdata_o (wave_rdata)
  );

  logic [23:0] acc_new;

  pslg_ram #(
    .WIDTH (24),
    .DEPTH (CHANNELS)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (ch_q),
    .wdata_i (acc_new),
    .raddr_i (ch_q),
    .rdata_o (acc_rdata)
  );

  assign ch_last = (ch_q == CW'(CHANNELS - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pslg_pkg::ST_IDLE: begin
        if (s_axis_tvalid && !s_axis_tuser[0]) begin
          state_d = pslg_pkg::ST_RD;
        end
      end
      pslg_pkg::ST_RD:  state_d = pslg_pkg::ST_ADV;
      pslg_pkg::ST_ADV: state_d = pslg_pkg::ST_PH;
      pslg_pkg::ST_PH:  state_d = pslg_pkg::ST_SIN;
      pslg_pkg::ST_SIN: state_d = pslg_pkg::ST_MUL;
      pslg_pkg::ST_MUL: state_d = pslg_pkg::ST_RND;
      pslg_pkg::ST_RND: state_d = pslg_pkg::ST_OUT;
      pslg_pkg::ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          state_d = ch_last ? pslg_pkg::ST_IDLE : pslg_pkg::ST_RD;
        end
      end
      default: state_d = pslg_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    tick_start    = 1'b0;
    wave_we       = 1'b0;
    acc_we        = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      pslg_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        tick_start    = s_axis_tvalid && !s_axis_tuser[0];
        wave_we       = s_axis_tvalid && s_axis_tuser[0] && sel_in_range;
      end
      pslg_pkg::ST_PH:  acc_we   = 1'b1;
      pslg_pkg::ST_OUT: out_load = !m_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  // datapath
  logic [47:0] adv_prod;
  logic [23:0] phase;
  logic [SINE_TABLE_BITS-1:0] sine_idx;
  logic [1:0]  quad;
  logic [SINE_TABLE_BITS-3:0] quad_rem;
  logic [RW-1:0] rom_addr;
  logic [62:0] rnd_sum;
  logic signed [33:0] sum;
  logic signed [31:0] sat;
  logic signed [31:0] clamped;

  assign wave_cur = wave_valid_q[ch_q] ? wave_rdata : '0;
  assign adv_prod = wave_cur.frequency * ts_q;
  assign acc_new  = acc_q + adv_q;
  assign phase    = acc_new + lead_q;
  assign sine_idx = phase[23 -: SINE_TABLE_BITS];
  assign quad     = sine_idx[SINE_TABLE_BITS-1 -: 2];
  assign quad_rem = sine_idx[SINE_TABLE_BITS-3:0];
  // second and fourth quarters read the table mirrored
  assign rom_addr = quad[0] ? (RW'(QUARTER) - RW'(quad_rem)) : RW'(quad_rem);
  assign rnd_sum  = mul_q + 63'(1 << 29);

  always_comb begin
    if (amp_neg_q ^ sin_neg_q) begin
      sum = {{2{off_q[31]}}, off_q} - {2'b00, mag_q};
    end else begin
      sum = {{2{off_q[31]}}, off_q} + {2'b00, mag_q};
    end
    if (sum[33:31] != {3{sum[33]}}) begin
      sat = sum[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat = sum[31:0];
    end
    // lower test first, so crossed limits fall to one of the two
    if (sat <= lower_q) begin
      clamped = lower_q;
    end else if (sat >= upper_q) begin
      clamped = upper_q;
    end else begin
      clamped = sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_start) begin
      ts_q   <= in_time_step;
      lead_q <= '0;
    end
    if (state_q == pslg_pkg::ST_ADV) begin
      adv_q     <= adv_prod[39:16];
      acc_q     <= acc_valid_q[ch_q] ? acc_rdata : '0;
      am_q      <= wave_cur.amplitude[31] ? (32'd0 - wave_cur.amplitude)
                                          : wave_cur.amplitude;
      amp_neg_q <= wave_cur.amplitude[31];
      off_q     <= wave_cur.offset;
      step_q    <= wave_cur.phase_step;
    end
    if (state_q == pslg_pkg::ST_PH) begin
      rom_addr_q <= rom_addr;
      sin_neg_q  <= quad[1];
      lead_q     <= lead_q + step_q;
    end
    if (state_q == pslg_pkg::ST_SIN) begin
      sine_q <= sine_rom[rom_addr_q];
    end
    if (state_q == pslg_pkg::ST_MUL) begin
      mul_q <= am_q * sine_q;
    end
    if (state_q == pslg_pkg::ST_RND) begin
      mag_q <= rnd_sum[61:30];
    end
    if (out_load) begin
      m_chan_q <= 3'(ch_q);
      m_len_q  <= clamped;
      m_last_q <= ch_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pslg_pkg::ST_IDLE;
      ch_q         <= '0;
      wave_valid_q <= '0;
      acc_valid_q  <= '0;
      m_valid_q    <= 1'b0;
      lower_q      <= 32'sd0;
      upper_q      <= 32'sh7fff_ffff;
    end else begin
      state_q <= state_d;
      if (tick_start) begin
        ch_q <= '0;
      end else if (out_load && !ch_last) begin
        ch_q <= ch_q + CW'(1);
      end
      if (wave_we) begin
        wave_valid_q[sel_ext[CW-1:0]] <= 1'b1;
      end
      if (acc_we) begin
        acc_valid_q[ch_q] <= 1'b1;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (psel && penable && pwrite) begin
        unique case (paddr[2])
          pslg_pkg::REG_LOWER: lower_q <= pwdata;
          pslg_pkg::REG_UPPER: upper_q <= pwdata;
          default: ;
        endcase
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'b0, m_len_q, m_chan_q};
  assign m_axis_tlast  = m_last_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == pslg_pkg::REG_UPPER) ? upper_q : lower_q;

endmodule
